>>> design/plel_pkg.sv
// shared types and codes for the positional list engine
package plel_pkg;

  localparam int unsigned VAL_W = 32;
  localparam int unsigned POS_W = 5;
  localparam int unsigned REQ_W = 3;
  localparam int unsigned ST_W  = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND  = 3'd0,
    REQ_INSERT  = 3'd1,
    REQ_DELETE  = 3'd2,
    REQ_REVERSE = 3'd3,
    REQ_DUMP    = 3'd4
  } req_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // what a cell loads on the next edge
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT,
    CELL_FROM_HEAD
  } cell_cmd_t;

endpackage

>>> design/plel_cell.sv
// one list cell: holds a value and loads from a neighbor, the head or the new value
module plel_cell (
  input  logic                         clk,
  input  plel_pkg::cell_cmd_t          cmd,
  input  logic [plel_pkg::VAL_W-1:0]   left_i,
  input  logic [plel_pkg::VAL_W-1:0]   right_i,
  input  logic [plel_pkg::VAL_W-1:0]   head_i,
  input  logic [plel_pkg::VAL_W-1:0]   new_i,
  output logic [plel_pkg::VAL_W-1:0]   val_o
);

  logic [plel_pkg::VAL_W-1:0] val_r;
  logic [plel_pkg::VAL_W-1:0] val_nxt;

  always_comb begin
    case (cmd)
      plel_pkg::CELL_LOAD:       val_nxt = new_i;
      plel_pkg::CELL_FROM_LEFT:  val_nxt = left_i;
      plel_pkg::CELL_FROM_RIGHT: val_nxt = right_i;
      plel_pkg::CELL_FROM_HEAD:  val_nxt = head_i;
      default:                   val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val_o = val_r;

endmodule

>>> design/positional_list_engine.sv
// top level of the positional list engine: cell row, request control and result register
module positional_list_engine #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // position[4:0], item_value[36:5], zero fill
  input  logic [2:0]  in_tuser,   // req_type[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // item_value_out[31:0]
  output logic [1:0]  out_tuser,  // status[1:0]
  output logic        out_tlast
);

  // The list lives in a row of CAPACITY cells, head in cell 0, and each cell
  // loads only from its neighbors, the head or the incoming value. Append,
  // insert and delete are done when taken: the cells past the position shift by
  // one place together, and the status result is registered in that cycle.
  // Reverse returns its status at once, then runs count rounds of alternating
  // pairwise swaps before the next request is taken. Dump streams one value
  // per cycle from cell 0 while the output is not stalled, as the row rotates
  // toward the head, and leaves the list as it was. A request is taken only
  // when no reverse or dump is running and the result register is free or
  // being emptied in the same cycle.

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CW    = (CNT_W > plel_pkg::POS_W + 1) ? CNT_W : plel_pkg::POS_W + 1;
  localparam int unsigned VW    = plel_pkg::VAL_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REV,
    S_DUMP
  } state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  step_r;
  logic              out_valid_r;
  logic [VW-1:0]     out_val_r;
  plel_pkg::status_t out_st_r;
  logic              out_last_r;

  logic [plel_pkg::POS_W-1:0] in_pos;
  logic [VW-1:0]              in_val;
  plel_pkg::req_t             in_req;
  logic                       in_acc;
  logic                       out_free;

  logic [CW-1:0] cnt_x;
  logic [CW-1:0] pos_x;
  logic          is_full;
  logic          ins_ok;
  logic          del_ok;
  logic          app_ok;
  logic          dump_go;

  logic [VW-1:0] cell_val [CAPACITY];
  plel_pkg::cell_cmd_t cell_cmd [CAPACITY];

  assign in_pos = in_tdata[4:0];
  assign in_val = in_tdata[36:5];
  assign in_req = plel_pkg::req_t'(in_tuser);

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign in_acc    = in_tvalid && in_tready;

  assign cnt_x   = CW'(count_r);
  assign pos_x   = CW'(in_pos);
  assign is_full = (count_r >= CNT_W'(CAPACITY));
  assign app_ok  = !is_full;
  assign ins_ok  = (pos_x != '0) && (pos_x <= cnt_x + CW'(1)) && !is_full;
  assign del_ok  = (count_r != '0) && (pos_x != '0) && (pos_x <= cnt_x);
  assign dump_go = (state_r == S_DUMP) && out_free;

  // per-cell command: each cell decides from its own index
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CW-1:0] IDX = CW'(i);
    localparam logic          PAR = 1'(i % 2);

    logic [VW-1:0] left_v;
    logic [VW-1:0] right_v;

    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_final
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = cell_val[i+1];
    end

    always_comb begin
      cell_cmd[i] = plel_pkg::CELL_HOLD;
      if (in_acc) begin
        case (in_req)
          plel_pkg::REQ_APPEND: begin
            if (app_ok && IDX == cnt_x) cell_cmd[i] = plel_pkg::CELL_LOAD;
          end
          plel_pkg::REQ_INSERT: begin
            if (ins_ok) begin
              if (IDX + CW'(1) == pos_x) cell_cmd[i] = plel_pkg::CELL_LOAD;
              else if (IDX + CW'(1) > pos_x && IDX <= cnt_x)
                cell_cmd[i] = plel_pkg::CELL_FROM_LEFT;
            end
          end
          plel_pkg::REQ_DELETE: begin
            if (del_ok && IDX + CW'(1) >= pos_x && IDX + CW'(1) < cnt_x)
              cell_cmd[i] = plel_pkg::CELL_FROM_RIGHT;
          end
          default: cell_cmd[i] = plel_pkg::CELL_HOLD;
        endcase
      end else if (state_r == S_REV) begin
        // pairs start on cells whose parity matches the round
        if (PAR == step_r[0]) begin
          if (IDX + CW'(1) < cnt_x) cell_cmd[i] = plel_pkg::CELL_FROM_RIGHT;
        end else if (i != 0 && IDX < cnt_x) begin
          cell_cmd[i] = plel_pkg::CELL_FROM_LEFT;
        end
      end else if (dump_go) begin
        if (IDX + CW'(1) < cnt_x) cell_cmd[i] = plel_pkg::CELL_FROM_RIGHT;
        else if (IDX + CW'(1) == cnt_x) cell_cmd[i] = plel_pkg::CELL_FROM_HEAD;
      end
    end

    plel_cell u_cell (
      .clk     (clk),
      .cmd     (cell_cmd[i]),
      .left_i  (left_v),
      .right_i (right_v),
      .head_i  (cell_val[0]),
      .new_i   (in_val),
      .val_o   (cell_val[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            // a non-empty dump sends its first value from the dump state, in the following cycle
            out_valid_r <= !(in_req == plel_pkg::REQ_DUMP && count_r != '0);
            out_val_r   <= '0;
            out_last_r  <= 1'b1;
            step_r      <= '0;
            case (in_req)
              plel_pkg::REQ_APPEND: begin
                out_st_r <= app_ok ? plel_pkg::ST_OK : plel_pkg::ST_FULL;
                if (app_ok) count_r <= count_r + CNT_W'(1);
              end
              plel_pkg::REQ_INSERT: begin
                if (pos_x == '0 || pos_x > cnt_x + CW'(1)) out_st_r <= plel_pkg::ST_RANGE;
                else if (is_full) out_st_r <= plel_pkg::ST_FULL;
                else out_st_r <= plel_pkg::ST_OK;
                if (ins_ok) count_r <= count_r + CNT_W'(1);
              end
              plel_pkg::REQ_DELETE: begin
                if (count_r == '0) out_st_r <= plel_pkg::ST_EMPTY;
                else if (!del_ok) out_st_r <= plel_pkg::ST_RANGE;
                else out_st_r <= plel_pkg::ST_OK;
                if (del_ok) count_r <= count_r - CNT_W'(1);
              end
              plel_pkg::REQ_REVERSE: begin
                out_st_r <= plel_pkg::ST_OK;
                if (count_r > CNT_W'(1)) state_r <= S_REV;
              end
              plel_pkg::REQ_DUMP: begin
                if (count_r == '0) begin
                  out_st_r <= plel_pkg::ST_EMPTY;
                end else begin
                  state_r <= S_DUMP;
                end
              end
              default: out_st_r <= plel_pkg::ST_RANGE;
            endcase
          end else if (out_tready) begin
            out_valid_r <= 1'b0;
          end
        end
        S_REV: begin
          if (out_tready) out_valid_r <= 1'b0;
          step_r <= step_r + CNT_W'(1);
          if (step_r + CNT_W'(1) == count_r) state_r <= S_IDLE;
        end
        S_DUMP: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_val_r   <= cell_val[0];
            out_st_r    <= plel_pkg::ST_OK;
            out_last_r  <= (step_r + CNT_W'(1) == count_r);
            step_r      <= step_r + CNT_W'(1);
            if (step_r + CNT_W'(1) == count_r) state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_val_r;
  assign out_tuser  = out_st_r;
  assign out_tlast  = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("list count above capacity");

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready)
    else $error("request taken during reverse or dump");

  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_req == plel_pkg::REQ_APPEND && !is_full)
      |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("append did not grow the list");

  a_dump_result_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DUMP && out_valid_r) |-> (out_st_r == plel_pkg::ST_OK && !out_last_r))
    else $error("dump value flagged wrongly while stream continues");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the positional list engine: directed and random requests
module tb_top;

  localparam int unsigned CAP = 16;
  localparam int unsigned N_RANDOM = 440;

  typedef struct {
    logic [plel_pkg::REQ_W-1:0] kind;
    logic [plel_pkg::POS_W-1:0] pos;
    logic [plel_pkg::VAL_W-1:0] val;
    bit                         settle;  // hold off until every pending result is back
  } list_req_t;

  typedef struct {
    logic [plel_pkg::VAL_W-1:0] value;
    plel_pkg::status_t          status;
    logic                       last;
  } list_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [39:0]      in_tdata = '0;   // position[4:0], item_value[36:5], zero fill
  logic [2:0]       in_tuser = '0;   // req_type[2:0]
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [31:0]      out_tdata;       // item_value_out[31:0]
  logic [1:0]       out_tuser;       // status[1:0]
  logic             out_tlast;

  list_req_t        pend_q[$];
  list_result_t     want_q[$];
  list_req_t        drv_req;
  list_result_t     want;

  // shadow list kept by the predictor
  logic [plel_pkg::VAL_W-1:0] shadow_cells[CAP];
  int               shadow_count = 0;

  // count seen by the stimulus generator while it builds the queue
  int               gen_count = 0;

  int               fail_count = 0;
  int               n_sent = 0;
  int               n_checked = 0;
  int               n_full = 0;
  int               n_range = 0;
  int               n_dump_values = 0;
  int               gap_left = 0;
  int               stall_left = 0;
  bit               in_gaps = 1'b1;
  bit               out_stalls = 1'b1;
  bit               calm = 1'b0;

  positional_list_engine #(.CAPACITY(CAP)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic void note_status(input plel_pkg::status_t st);
    list_result_t res;
    res.value = '0;
    res.status = st;
    res.last = 1'b1;
    want_q.push_back(res);
    if (st == plel_pkg::ST_FULL) n_full++;
    if (st == plel_pkg::ST_RANGE) n_range++;
  endfunction

  // advances the shadow list by one request and queues the results it causes
  function automatic void apply_request(input list_req_t r);
    int i;
    int lo;
    int hi;
    logic [plel_pkg::VAL_W-1:0] t;
    list_result_t res;
    case (r.kind)
      plel_pkg::REQ_APPEND: begin
        if (shadow_count >= CAP) begin
          note_status(plel_pkg::ST_FULL);
        end else begin
          shadow_cells[shadow_count] = r.val;
          shadow_count++;
          note_status(plel_pkg::ST_OK);
        end
      end
      plel_pkg::REQ_INSERT: begin
        if (r.pos < 1 || r.pos > shadow_count + 1) begin
          note_status(plel_pkg::ST_RANGE);
        end else if (shadow_count >= CAP) begin
          note_status(plel_pkg::ST_FULL);
        end else begin
          for (i = shadow_count; i > r.pos - 1; i--) shadow_cells[i] = shadow_cells[i-1];
          shadow_cells[r.pos-1] = r.val;
          shadow_count++;
          note_status(plel_pkg::ST_OK);
        end
      end
      plel_pkg::REQ_DELETE: begin
        if (shadow_count == 0) begin
          note_status(plel_pkg::ST_EMPTY);
        end else if (r.pos < 1 || r.pos > shadow_count) begin
          note_status(plel_pkg::ST_RANGE);
        end else begin
          for (i = r.pos - 1; i + 1 < shadow_count; i++) shadow_cells[i] = shadow_cells[i+1];
          shadow_count--;
          note_status(plel_pkg::ST_OK);
        end
      end
      plel_pkg::REQ_REVERSE: begin
        lo = 0;
        hi = shadow_count - 1;
        while (lo < hi) begin
          t = shadow_cells[lo];
          shadow_cells[lo] = shadow_cells[hi];
          shadow_cells[hi] = t;
          lo++;
          hi--;
        end
        note_status(plel_pkg::ST_OK);
      end
      plel_pkg::REQ_DUMP: begin
        if (shadow_count == 0) begin
          note_status(plel_pkg::ST_EMPTY);
        end else begin
          for (i = 0; i < shadow_count; i++) begin
            res.value = shadow_cells[i];
            res.status = plel_pkg::ST_OK;
            res.last = (i + 1 == shadow_count);
            want_q.push_back(res);
            n_dump_values++;
          end
        end
      end
      default: note_status(plel_pkg::ST_RANGE);
    endcase
  endfunction

  function automatic logic [plel_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(0, 11))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_req(input logic [plel_pkg::REQ_W-1:0] kind, input int pos,
                           input logic [plel_pkg::VAL_W-1:0] val, input bit settle);
    list_req_t r;
    r.kind = kind;
    r.pos = pos[plel_pkg::POS_W-1:0];
    r.val = val;
    r.settle = settle;
    pend_q.push_back(r);
    // track the list length so that positions can be aimed at valid slots
    if (kind == plel_pkg::REQ_APPEND && gen_count < CAP) gen_count++;
    if (kind == plel_pkg::REQ_INSERT && pos >= 1 && pos <= gen_count + 1 && gen_count < CAP)
      gen_count++;
    if (kind == plel_pkg::REQ_DELETE && pos >= 1 && pos <= gen_count) gen_count--;
  endtask

  task automatic queue_random_op();
    int r;
    int pos;
    r = $urandom_range(0, 99);
    if (r < 28) begin
      queue_req(plel_pkg::REQ_APPEND, $urandom_range(0, 31), pick_value(), 1'b0);
    end else if (r < 52) begin
      pos = ($urandom_range(0, 9) != 0) ? $urandom_range(1, gen_count + 1) : $urandom_range(0, 31);
      queue_req(plel_pkg::REQ_INSERT, pos, pick_value(), 1'b0);
    end else if (r < 74) begin
      pos = (gen_count != 0 && $urandom_range(0, 9) != 0) ?
            $urandom_range(1, gen_count) : $urandom_range(0, 31);
      queue_req(plel_pkg::REQ_DELETE, pos, pick_value(), 1'b0);
    end else if (r < 84) begin
      queue_req(plel_pkg::REQ_REVERSE, $urandom_range(0, 31), pick_value(), 1'b0);
    end else if (r < 95) begin
      queue_req(plel_pkg::REQ_DUMP, $urandom_range(0, 31), pick_value(), 1'b0);
    end else begin
      queue_req(3'($urandom_range(5, 7)), $urandom_range(0, 31), pick_value(), 1'b0);
    end
  endtask

  // driver: presents one request per transaction, prediction runs when it is put on the bus
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left <= 0;
    end else begin
      calm <= (pend_q.size() < 50);
      if ($urandom_range(0, 63) == 0) in_gaps <= !in_gaps;
      if (!in_tvalid || in_tready) begin
        if (in_tvalid) n_sent++;
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (pend_q.size() == 0 || (pend_q[0].settle && want_q.size() != 0)) begin
          in_tvalid <= 1'b0;
        end else begin
          drv_req = pend_q.pop_front();
          apply_request(drv_req);
          in_tdata <= {3'b000, drv_req.val, drv_req.pos};
          in_tuser <= drv_req.kind;
          in_tvalid <= 1'b1;
          if (!calm && in_gaps && $urandom_range(0, 3) == 0) gap_left <= $urandom_range(1, 8);
        end
      end
    end
  end

  // monitor: checks each result transaction against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (want_q.size() == 0) begin
          flag_mismatch($sformatf("result with nothing pending: value %h status %0d last %b",
                                  out_tdata, out_tuser, out_tlast));
        end else begin
          want = want_q.pop_front();
          n_checked++;
          if (out_tdata !== want.value)
            flag_mismatch($sformatf("value %h, predicted %h", out_tdata, want.value));
          if (out_tuser !== want.status)
            flag_mismatch($sformatf("status %0d, predicted %s", out_tuser, want.status.name()));
          if (out_tlast !== want.last)
            flag_mismatch($sformatf("last %b, predicted %b", out_tlast, want.last));
        end
      end
      if ($urandom_range(0, 63) == 0) out_stalls <= !out_stalls;
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_tready <= 1'b0;
      end else if (!calm && out_stalls && $urandom_range(0, 4) == 0) begin
        stall_left <= $urandom_range(0, 7);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    int k;
    // directed: empty list corners, extreme values, edges of the position range
    queue_req(plel_pkg::REQ_DUMP, 0, 32'h0, 1'b0);
    queue_req(plel_pkg::REQ_DELETE, 0, 32'h0, 1'b0);
    queue_req(plel_pkg::REQ_DELETE, 31, 32'hffff_ffff, 1'b0);
    queue_req(plel_pkg::REQ_REVERSE, 0, 32'h0, 1'b0);
    queue_req(plel_pkg::REQ_INSERT, 0, 32'h1234_5678, 1'b0);
    queue_req(plel_pkg::REQ_INSERT, 2, 32'h1234_5678, 1'b0);
    queue_req(plel_pkg::REQ_INSERT, 1, 32'h8000_0000, 1'b0);
    queue_req(plel_pkg::REQ_REVERSE, 31, 32'h0, 1'b0);
    queue_req(plel_pkg::REQ_APPEND, 31, 32'h7fff_ffff, 1'b0);
    queue_req(plel_pkg::REQ_APPEND, 0, 32'hffff_ffff, 1'b0);
    queue_req(plel_pkg::REQ_INSERT, 4, 32'h0000_0000, 1'b0);
    queue_req(plel_pkg::REQ_INSERT, 2, 32'haaaa_aaaa, 1'b0);
    queue_req(plel_pkg::REQ_REVERSE, 0, 32'h0, 1'b0);
    queue_req(plel_pkg::REQ_DUMP, 0, 32'h0, 1'b0);
    queue_req(plel_pkg::REQ_DELETE, 0, 32'h0, 1'b0);
    queue_req(plel_pkg::REQ_DELETE, 6, 32'h0, 1'b0);
    queue_req(plel_pkg::REQ_DELETE, 5, 32'h0, 1'b0);
    queue_req(plel_pkg::REQ_DELETE, 1, 32'h0, 1'b0);
    queue_req(3'd5, 1, 32'h5555_5555, 1'b0);
    queue_req(3'd6, 17, 32'h0, 1'b0);
    queue_req(3'd7, 31, 32'hffff_ffff, 1'b0);
    queue_req(plel_pkg::REQ_DUMP, 0, 32'h0, 1'b0);

    k = 0;
    while (k < N_RANDOM) begin
      if (k == 0 || $urandom_range(0, 39) == 0) begin
        // fill to capacity, then poke at the full list
        queue_req(plel_pkg::REQ_APPEND, $urandom_range(0, 31), pick_value(), 1'b1);
        k++;
        while (gen_count < CAP) begin
          queue_req(plel_pkg::REQ_INSERT, $urandom_range(1, gen_count + 1), pick_value(), 1'b0);
          k++;
        end
        queue_req(plel_pkg::REQ_APPEND, $urandom_range(0, 31), pick_value(), 1'b0);
        queue_req(plel_pkg::REQ_INSERT, $urandom_range(1, CAP + 1), pick_value(), 1'b0);
        queue_req(plel_pkg::REQ_INSERT, $urandom_range(CAP + 2, 31), pick_value(), 1'b0);
        queue_req(plel_pkg::REQ_REVERSE, 0, 32'h0, 1'b0);
        queue_req(plel_pkg::REQ_DUMP, 0, 32'h0, 1'b0);
        k += 5;
      end else if ($urandom_range(0, 39) == 0) begin
        // empty the list from random positions
        while (gen_count > 0) begin
          queue_req(plel_pkg::REQ_DELETE, $urandom_range(1, gen_count), pick_value(), 1'b0);
          k++;
        end
        queue_req(plel_pkg::REQ_DELETE, $urandom_range(0, 31), pick_value(), 1'b0);
        queue_req(plel_pkg::REQ_DUMP, 0, 32'h0, 1'b0);
        k += 2;
      end else begin
        queue_random_op();
        k++;
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (pend_q.size() != 0 || in_tvalid || want_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d requests sent, %0d results checked (%0d dump values)",
             n_sent, n_checked, n_dump_values);
    $display("full status predicted %0d times, out of range %0d times", n_full, n_range);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d results still pending", want_q.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
